>>> rtl/dhm_pkg.sv
// Package for the duration histogram block: state encoding, ALU operation codes,
// ALU request and response structs, and the fixed constants of the histogram.
// Used by dhm_alu, duration_histogram_median_max and the testbench. Depends on nothing.
package dhm_pkg;

    // Width of the shared adder / subtractor datapath.
    localparam int unsigned ALU_W         = 32;
    // Width of one bin count and of the sample total.
    localparam int unsigned COUNT_W       = 31;
    // Width of the reported bin index fields.
    localparam int unsigned BIN_FIELD_W   = 6;
    // Duration ticks per histogram bin.
    localparam int unsigned TICKS_PER_BIN = 50;
    // A total above this value triggers the halving pass.
    localparam logic [COUNT_W-1:0] HALVE_LIMIT = 31'h7000_0000;

    // The bin index of an unsaturated duration is taken as
    // (duration * RECIP_MULT) >> RECIP_SHIFT. RECIP_MULT is 2**RECIP_SHIFT / TICKS_PER_BIN
    // rounded up, and the quotient is exact for every dividend below 2**DIVIDEND_W,
    // which covers all durations below the saturation point for up to 1024 bins.
    localparam int unsigned DIVIDEND_W  = 16;
    localparam int unsigned RECIP_SHIFT = 23;
    localparam int unsigned RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd167773;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] result;
        logic             borrow;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_INC_RD,
        S_INC_WR,
        S_TOT,
        S_HALVE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

>>> rtl/dhm_alu.sv
// Shared adder / subtractor of the duration histogram block.
// Serves the saturation check, the increments, the halving sum and the median scan.
// Depends on dhm_pkg for the request and response structs.
module dhm_alu (
    input  dhm_pkg::t_alu_req i_req,
    output dhm_pkg::t_alu_rsp o_rsp
);

    logic [dhm_pkg::ALU_W:0] w_full;

    always_comb begin
        case (i_req.op)
            dhm_pkg::ALU_SUB: w_full = {1'b0, i_req.a} - {1'b0, i_req.b};
            default:          w_full = {1'b0, i_req.a} + {1'b0, i_req.b};
        endcase
    end

    // On a subtraction the top bit is the borrow, set when a is below b.
    assign o_rsp.result = w_full[dhm_pkg::ALU_W-1:0];
    assign o_rsp.borrow = (i_req.op == dhm_pkg::ALU_SUB) ? w_full[dhm_pkg::ALU_W] : 1'b0;

endmodule

>>> rtl/dhm_bin_ram.sv
// Bin count memory of the duration histogram block.
// One write port and one read port with registered read data.
// Depends on nothing; widths come from its parameters.
module dhm_bin_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned DATA_W = 31
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/duration_histogram_median_max.sv
// Top level of the duration histogram: sequencer, bin memory and shared ALU.
// Depends on dhm_pkg, dhm_alu and dhm_bin_ram.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_clear, i_duration
//   result   out        o_valid / i_ready    o_median_bin, o_max_bin, o_sample_total
//
// A sample transaction passes the division state unless the duration saturates into
// the last bin, then reads, increments and writes back one bin and walks all bins in
// the scan, plus one walk in the halving pass when it runs; a clear walks them twice.
// Its length is set by the single read port of the bin memory, which the halving pass
// and the combined median and maximum scan walk one bin per cycle.
// After reset a clearing pass zeroes the memory; o_ready stays low.
// A result waits in the output register while the next transaction is accepted and
// processed; the sequencer holds in its final state only if that register is still full.
module duration_histogram_median_max #(
    parameter int unsigned NUM_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_clear,
    input  logic [31:0] i_duration,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_median_bin,
    output logic [5:0]  o_max_bin,
    output logic [30:0] o_sample_total
);

    localparam int unsigned ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned CNT_W  = $clog2(NUM_BINS + 1);
    localparam int unsigned ALU_W  = dhm_pkg::ALU_W;
    localparam int unsigned CW     = dhm_pkg::COUNT_W;
    localparam int unsigned BF_W   = dhm_pkg::BIN_FIELD_W;
    localparam int unsigned DV_W   = dhm_pkg::DIVIDEND_W;
    localparam int unsigned PROD_W = dhm_pkg::DIVIDEND_W + dhm_pkg::RECIP_W;

    localparam logic [ADDR_W-1:0] LAST_BIN  = ADDR_W'(NUM_BINS - 1);
    localparam logic [CNT_W-1:0]  ISSUE_END = CNT_W'(NUM_BINS);
    // Durations at or above this value land in the last bin.
    localparam logic [ALU_W-1:0]  SAT_LIM   =
        ALU_W'(dhm_pkg::TICKS_PER_BIN * (NUM_BINS - 1));

    // Control state.
    dhm_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rv, n_rv;
    logic              r_item, n_item;
    logic              r_out_valid, n_out_valid;
    logic [CW-1:0]     r_total, n_total;

    // Datapath registers.
    logic [DV_W-1:0]   r_rem, n_rem;
    logic [ADDR_W-1:0] r_bin, n_bin;
    logic [ADDR_W-1:0] r_widx, n_widx;
    logic [ALU_W-1:0]  r_acc, n_acc;
    logic              r_found, n_found;
    logic [BF_W-1:0]   r_med, n_med;
    logic [BF_W-1:0]   r_max, n_max;
    logic [BF_W-1:0]   r_o_med, n_o_med;
    logic [BF_W-1:0]   r_o_max, n_o_max;
    logic [CW-1:0]     r_o_total, n_o_total;

    // Memory and ALU connections.
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [CW-1:0]     w_wdata, w_rdata;
    logic [ALU_W-1:0]  w_half;
    logic [PROD_W-1:0] w_prod;
    dhm_pkg::t_alu_req w_alu_req;
    dhm_pkg::t_alu_rsp w_alu_rsp;

    dhm_bin_ram #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (ADDR_W),
        .DATA_W (CW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dhm_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // Half of the total, rounded down, is the median target.
    assign w_half = ALU_W'(r_total >> 1);

    // An unsaturated duration is below the saturation point, so its low bits alone
    // give the bin through one multiplication by the scaled reciprocal of the bin width.
    assign w_prod = PROD_W'(r_rem) * PROD_W'(dhm_pkg::RECIP_MULT);

    // Operand selection for the shared ALU. Each state uses it for one job.
    always_comb begin
        w_alu_req.op = dhm_pkg::ALU_ADD;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        unique case (r_state)
            dhm_pkg::S_IDLE: begin
                // Saturation check of the incoming duration.
                w_alu_req.op = dhm_pkg::ALU_SUB;
                w_alu_req.a  = i_duration;
                w_alu_req.b  = SAT_LIM;
            end
            dhm_pkg::S_INC_WR: begin
                w_alu_req.a = ALU_W'(w_rdata);
                w_alu_req.b = ALU_W'(1);
            end
            dhm_pkg::S_TOT: begin
                w_alu_req.a = ALU_W'(r_total);
                w_alu_req.b = ALU_W'(1);
            end
            dhm_pkg::S_HALVE: begin
                w_alu_req.a = r_acc;
                w_alu_req.b = ALU_W'(w_rdata >> 1);
            end
            dhm_pkg::S_SCAN: begin
                w_alu_req.a = r_acc;
                w_alu_req.b = ALU_W'(w_rdata);
            end
            default: begin
                w_alu_req.op = dhm_pkg::ALU_ADD;
            end
        endcase
    end

    // Sequencer: next state, memory control and register updates.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rv        = r_rv;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_total     = r_total;
        n_rem       = r_rem;
        n_bin       = r_bin;
        n_widx      = r_widx;
        n_acc       = r_acc;
        n_found     = r_found;
        n_med       = r_med;
        n_max       = r_max;
        n_o_med     = r_o_med;
        n_o_max     = r_o_max;
        n_o_total   = r_o_total;
        w_we        = 1'b0;
        w_waddr     = r_widx;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = r_idx[ADDR_W-1:0];
        o_ready     = 1'b0;

        // The downstream side takes the waiting result.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            dhm_pkg::S_INIT: begin
                // Clearing pass, after reset or for a clear transaction.
                w_we    = 1'b1;
                w_waddr = r_idx[ADDR_W-1:0];
                n_idx   = r_idx + CNT_W'(1);
                if (r_idx[ADDR_W-1:0] == LAST_BIN) begin
                    if (r_item) begin
                        n_state = dhm_pkg::S_SCAN;
                        n_idx   = '0;
                        n_rv    = 1'b0;
                        n_acc   = '0;
                        n_found = 1'b0;
                        n_med   = '0;
                        n_max   = '0;
                    end else begin
                        n_state = dhm_pkg::S_IDLE;
                    end
                end
            end
            dhm_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_item = 1'b1;
                    if (i_clear) begin
                        n_total = '0;
                        n_idx   = '0;
                        n_state = dhm_pkg::S_INIT;
                    end else begin
                        n_rem = i_duration[DV_W-1:0];
                        n_bin = '0;
                        if (!w_alu_rsp.borrow) begin
                            n_bin   = LAST_BIN;
                            n_state = dhm_pkg::S_INC_RD;
                        end else begin
                            n_state = dhm_pkg::S_DIV;
                        end
                    end
                end
            end
            dhm_pkg::S_DIV: begin
                // The quotient is below the last bin, so it fits the bin index.
                n_bin   = w_prod[dhm_pkg::RECIP_SHIFT +: ADDR_W];
                n_state = dhm_pkg::S_INC_RD;
            end
            dhm_pkg::S_INC_RD: begin
                w_re    = 1'b1;
                w_raddr = r_bin;
                n_state = dhm_pkg::S_INC_WR;
            end
            dhm_pkg::S_INC_WR: begin
                w_we    = 1'b1;
                w_waddr = r_bin;
                w_wdata = w_alu_rsp.result[CW-1:0];
                n_state = dhm_pkg::S_TOT;
            end
            dhm_pkg::S_TOT: begin
                n_total = w_alu_rsp.result[CW-1:0];
                n_idx   = '0;
                n_rv    = 1'b0;
                n_acc   = '0;
                if (w_alu_rsp.result[CW-1:0] > dhm_pkg::HALVE_LIMIT) begin
                    n_state = dhm_pkg::S_HALVE;
                end else begin
                    n_state = dhm_pkg::S_SCAN;
                    n_found = 1'b0;
                    n_med   = '0;
                    n_max   = '0;
                end
            end
            dhm_pkg::S_HALVE: begin
                // Read one bin ahead while the previous one is written back halved.
                if (r_idx != ISSUE_END) begin
                    w_re  = 1'b1;
                    n_idx = r_idx + CNT_W'(1);
                end
                n_rv   = (r_idx != ISSUE_END);
                n_widx = r_idx[ADDR_W-1:0];
                if (r_rv) begin
                    w_we    = 1'b1;
                    w_waddr = r_widx;
                    w_wdata = w_rdata >> 1;
                    n_acc   = w_alu_rsp.result;
                    if (r_widx == LAST_BIN) begin
                        n_total = w_alu_rsp.result[CW-1:0];
                        n_state = dhm_pkg::S_SCAN;
                        n_idx   = '0;
                        n_rv    = 1'b0;
                        n_acc   = '0;
                        n_found = 1'b0;
                        n_med   = '0;
                        n_max   = '0;
                    end
                end
            end
            dhm_pkg::S_SCAN: begin
                // One pass finds both the median and the highest non-empty bin.
                if (r_idx != ISSUE_END) begin
                    w_re  = 1'b1;
                    n_idx = r_idx + CNT_W'(1);
                end
                n_rv   = (r_idx != ISSUE_END);
                n_widx = r_idx[ADDR_W-1:0];
                if (r_rv) begin
                    n_acc = w_alu_rsp.result;
                    if (!r_found && ((w_alu_rsp.result >= w_half) || (r_widx == LAST_BIN))) begin
                        n_found = 1'b1;
                        n_med   = BF_W'(r_widx);
                    end
                    if (w_rdata != '0) begin
                        n_max = BF_W'(r_widx);
                    end
                    if (r_widx == LAST_BIN) begin
                        n_state = dhm_pkg::S_DONE;
                    end
                end
            end
            dhm_pkg::S_DONE: begin
                // Hand over once the output register is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_med     = r_med;
                    n_o_max     = r_max;
                    n_o_total   = r_total;
                    n_state     = dhm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dhm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dhm_pkg::S_INIT;
            r_idx       <= '0;
            r_rv        <= 1'b0;
            r_item      <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rv        <= n_rv;
            r_item      <= n_item;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_bin     <= n_bin;
        r_widx    <= n_widx;
        r_acc     <= n_acc;
        r_found   <= n_found;
        r_med     <= n_med;
        r_max     <= n_max;
        r_o_med   <= n_o_med;
        r_o_max   <= n_o_max;
        r_o_total <= n_o_total;
    end

    assign o_valid        = r_out_valid;
    assign o_median_bin   = r_o_med;
    assign o_max_bin      = r_o_max;
    assign o_sample_total = r_o_total;

endmodule

>>> test/duration_histogram_median_max_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for duration_histogram_median_max (64 bins).
// Depends on dhm_pkg and the block; a local histogram predicts every result.
module duration_histogram_median_max_test;

    // The block runs with its default of 64 bins; the predictor mirrors that.
    localparam int unsigned NBINS         = 64;
    // The last bin index, used to build boundary durations.
    localparam int unsigned LAST_BIN      = NBINS - 1;
    // Watchdog limit. The slowest correct run is roughly 1700 transactions, each with
    // its sample path, halving pass, sender gap and receiver stall, plus one long
    // hold-off and the clearing pass after reset.
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int unsigned HOLD_CYCLES   = 600;
    // Cycles allowed after the last result for any stray output to show up.
    localparam int unsigned DRAIN_CYCLES  = 300;

    // One expected result transaction.
    typedef struct {
        logic [dhm_pkg::BIN_FIELD_W-1:0] median_bin;
        logic [dhm_pkg::BIN_FIELD_W-1:0] max_bin;
        logic [dhm_pkg::COUNT_W-1:0]     sample_total;
    } t_hist_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_clear;
    logic [31:0]            i_duration;
    logic                   o_valid;
    logic                   i_ready;
    logic [5:0]             o_median_bin;
    logic [5:0]             o_max_bin;
    logic [30:0]            o_sample_total;

    // Predictor state: a private copy of the bin store and the sample total.
    logic [dhm_pkg::COUNT_W-1:0] model_bins [NBINS];
    logic [dhm_pkg::COUNT_W-1:0] model_total;

    // Results predicted at input acceptance, oldest first.
    t_hist_result           pending_results [$];

    int unsigned            error_count;
    int unsigned            cycle_count;
    // When low, neither side inserts random idle bursts; a requested hold-off still runs.
    bit                     idling_on;
    // Set by a test to ask the receiver for one long hold-off.
    bit                     hold_request;

    duration_histogram_median_max #(
        .NUM_BINS(NBINS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_clear        (i_clear),
        .i_duration     (i_duration),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_bin   (o_median_bin),
        .o_max_bin      (o_max_bin),
        .o_sample_total (o_sample_total)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Every mismatch goes through here: one line and one count.
    task automatic report_mismatch(input string msg);
        begin
            error_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Empties the predicted histogram, as reset and a clear transaction do.
    task automatic histogram_clear();
        begin
            for (int i = 0; i < NBINS; i++) model_bins[i] = '0;
            model_total = '0;
        end
    endtask

    // Applies one input transaction to the predicted histogram and returns the
    // median bin, the highest occupied bin and the total that the block must report.
    task automatic histogram_apply(input logic clr, input logic [31:0] dur,
                                   output t_hist_result res);
        logic [31:0]                 bin;
        logic [dhm_pkg::COUNT_W-1:0] sum;
        logic [dhm_pkg::COUNT_W-1:0] half;
        logic [63:0]                 run;
        int unsigned                 idx;
        int unsigned                 top;
        begin
            if (clr) begin
                histogram_clear();
            end else begin
                bin = dur / dhm_pkg::TICKS_PER_BIN;
                if (bin > LAST_BIN) bin = LAST_BIN;
                model_bins[bin] = model_bins[bin] + 1'b1;
                model_total = model_total + 1'b1;
                // Past the limit every bin is halved and the total is summed again.
                if (model_total > dhm_pkg::HALVE_LIMIT) begin
                    sum = '0;
                    for (int i = 0; i < NBINS; i++) begin
                        model_bins[i] = model_bins[i] >> 1;
                        sum = sum + model_bins[i];
                    end
                    model_total = sum;
                end
            end

            // Median: first bin whose running sum reaches half the total (rounded
            // down), never past the last bin. An empty histogram gives bin 0.
            half = model_total >> 1;
            run  = 64'(model_bins[0]);
            idx  = 0;
            while (run < 64'(half) && idx < LAST_BIN) begin
                idx++;
                run += 64'(model_bins[idx]);
            end

            // Maximum: highest non-empty bin, 0 when nothing is counted.
            top = 0;
            for (int i = NBINS - 1; i >= 0; i--) begin
                if (model_bins[i] != '0 && top == 0) top = i;
            end

            res.median_bin   = idx[dhm_pkg::BIN_FIELD_W-1:0];
            res.max_bin      = top[dhm_pkg::BIN_FIELD_W-1:0];
            res.sample_total = model_total;
        end
    endtask

    // Sends one input transaction. An optional idle burst comes first; valid then
    // stays high with a steady payload until it is accepted.
    // The expected result is queued at the accepting edge.
    task automatic send_duration(input logic clr, input logic [31:0] dur);
        int unsigned  gap;
        t_hist_result res;
        begin
            gap = 0;
            if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
            @(negedge i_clk);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid    <= 1'b1;
            i_clear    <= clr;
            i_duration <= dur;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            histogram_apply(clr, dur, res);
            pending_results.push_back(res);
        end
    endtask

    // Random duration with most weight on the 64 bins themselves, and the rest on
    // bin edges, the saturating range and the full 32-bit range.
    function automatic logic [31:0] pick_duration();
        int unsigned sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55) return $urandom_range(0, dhm_pkg::TICKS_PER_BIN * NBINS - 1);
            else if (sel < 70)
                return $urandom_range(0, LAST_BIN) * dhm_pkg::TICKS_PER_BIN
                       + ($urandom_range(0, 1) ? dhm_pkg::TICKS_PER_BIN - 1 : 0);
            else if (sel < 80)
                return $urandom_range(dhm_pkg::TICKS_PER_BIN * LAST_BIN, 20000);
            else if (sel < 85)
                return $urandom_range(0, 6) * dhm_pkg::TICKS_PER_BIN;
            else return $urandom();
        end
    endfunction

    // Receiver. Ready drops in random bursts while idling is on, and for one long
    // stretch when a test asks for it. The long stretch is counted here so that the
    // sender can keep offering transactions meanwhile.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        t_hist_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: median %0d max %0d total %0d",
                                          o_median_bin, o_max_bin, o_sample_total));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_median_bin !== exp_res.median_bin)
                    report_mismatch($sformatf("median_bin got %0d expected %0d",
                                              o_median_bin, exp_res.median_bin));
                if (o_max_bin !== exp_res.max_bin)
                    report_mismatch($sformatf("max_bin got %0d expected %0d",
                                              o_max_bin, exp_res.max_bin));
                if (o_sample_total !== exp_res.sample_total)
                    report_mismatch($sformatf("sample_total got %0d expected %0d",
                                              o_sample_total, exp_res.sample_total));
            end
        end
    end

    // Clear on an empty histogram, with both extremes of the ignored duration.
    // All three result fields must read zero.
    task automatic test_empty_and_clear();
        begin
            send_duration(1'b1, 32'h0000_0000);
            send_duration(1'b1, 32'hFFFF_FFFF);
        end
    endtask

    // Bin boundaries at both ends, the first duration that saturates into the
    // last bin, and the largest durations, which must also land in the last bin.
    task automatic test_bin_edges();
        begin
            send_duration(1'b0, 32'd0);
            send_duration(1'b0, dhm_pkg::TICKS_PER_BIN - 1);
            send_duration(1'b0, dhm_pkg::TICKS_PER_BIN);
            send_duration(1'b0, dhm_pkg::TICKS_PER_BIN + 1);
            send_duration(1'b0, 2 * dhm_pkg::TICKS_PER_BIN - 1);
            send_duration(1'b0, 2 * dhm_pkg::TICKS_PER_BIN);
            send_duration(1'b0, dhm_pkg::TICKS_PER_BIN * LAST_BIN - 1);
            send_duration(1'b0, dhm_pkg::TICKS_PER_BIN * LAST_BIN);
            send_duration(1'b0, dhm_pkg::TICKS_PER_BIN * LAST_BIN + 1);
            send_duration(1'b0, 32'h8000_0000);
            send_duration(1'b0, 32'hFFFF_FFFF);
        end
    endtask

    // A small histogram built up one sample at a time, so the total runs through
    // odd and even values and the rounded-down half moves the median across bins.
    task automatic test_median_odd_totals();
        begin
            send_duration(1'b1, 32'd1234);
            send_duration(1'b0, 5 * dhm_pkg::TICKS_PER_BIN);
            send_duration(1'b0, 40 * dhm_pkg::TICKS_PER_BIN);
            send_duration(1'b0, 40 * dhm_pkg::TICKS_PER_BIN + 7);
            send_duration(1'b0, 5 * dhm_pkg::TICKS_PER_BIN + 49);
            send_duration(1'b0, 40 * dhm_pkg::TICKS_PER_BIN);
            send_duration(1'b1, 32'd0);
        end
    endtask

    // Random transactions in phases: some with idling on both sides, some with none.
    // A clear now and then keeps the histogram shape changing.
    task automatic test_random_mix();
        logic clr;
        begin
            for (int phase = 0; phase < 15; phase++) begin
                idling_on = ($urandom_range(0, 3) != 0);
                for (int n = 0; n < 104; n++) begin
                    clr = ($urandom_range(0, 59) == 0);
                    send_duration(clr, clr ? $urandom() : pick_duration());
                end
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // back-to-back transactions. The output register fills, the block finishes the
    // next transaction and then has to stall its input.
    task automatic test_backpressure_fill();
        begin
            idling_on    = 1'b0;
            hold_request = 1'b1;
            for (int n = 0; n < 40; n++) send_duration(1'b0, pick_duration());
        end
    endtask

    // Final stretch with no idling on either side.
    task automatic test_steady_stream();
        begin
            idling_on = 1'b0;
            for (int n = 0; n < 100; n++)
                send_duration(($urandom_range(0, 49) == 0), pick_duration());
        end
    endtask

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        idling_on    = 1'b1;
        hold_request = 1'b0;
        i_valid      = 1'b0;
        i_clear      = 1'b0;
        i_duration   = '0;
        i_rst_n      = 1'b0;
        histogram_clear();

        // Synchronous reset, released at a falling edge.
        // The block then runs its clearing pass with ready low; the first send
        // simply waits for it.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_clear();
        test_bin_edges();
        test_median_odd_totals();
        test_random_mix();
        test_backpressure_fill();
        test_steady_stream();

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain: all predictions must be met, then give stray outputs time to appear.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/dhm_pkg.sv
rtl/dhm_alu.sv
rtl/dhm_bin_ram.sv
rtl/duration_histogram_median_max.sv
test/duration_histogram_median_max_test.sv
